/* src/h2p_pkg.sv */
package h2p_pkg;

    // word widths and fixed-point positions
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROT_FRAC  = DATA_W - 2;

    // pipeline depths
    localparam int NORM_LAT   = 34;
    localparam int DIV_STAGES = 31;
    localparam int COL_LAT    = NORM_LAT + DIV_STAGES + 2;
    localparam int PIPE_LAT   = 2 * COL_LAT + 6;

    // one for rotation entries, and the data word maximum
    localparam logic [30:0] ROT_ONE  = 31'h4000_0000;
    localparam logic [31:0] DATA_MAX = 32'h7fff_ffff;

    // three signed components, one guard bit for a negated full-scale value
    typedef logic [2:0][32:0] t_vec3;
    // three rotation entries, signed Q2.30
    typedef logic [2:0][31:0] t_rot3;

    // clamp to the signed data word range
    function automatic logic [31:0] sat_data(input logic signed [71:0] v);
        logic [31:0] res;
        if (v > 72'sd2147483647) begin
            res = DATA_MAX;
        end else if (v < -72'sd2147483648) begin
            res = ~DATA_MAX;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // clamp to plus or minus one in Q2.30
    function automatic logic [31:0] sat_rot(input logic signed [71:0] v);
        logic [31:0] res;
        if (v > 72'sd1073741824) begin
            res = 32'h4000_0000;
        end else if (v < -72'sd1073741824) begin
            res = 32'hc000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

/* src/h2p_column.sv */
module h2p_column (
    input  logic             i_clk,
    input  logic             i_en,
    input  h2p_pkg::t_vec3   i_num,
    output logic [31:0]      o_norm,
    output h2p_pkg::t_rot3   o_rot
);

    logic [31:0]    w_mag [3];
    logic [32:0]    w_neg [3];
    logic [63:0]    r_sq [3];
    logic [63:0]    r_rem [33];
    logic [31:0]    r_root [33];
    logic [63:0]    n_rem [32];
    logic [31:0]    n_root [32];
    h2p_pkg::t_vec3 r_nd [h2p_pkg::NORM_LAT];

    logic [31:0]    w_pm [3];
    logic [32:0]    w_pneg [3];
    logic [32:0]    r_drem [h2p_pkg::DIV_STAGES+1][3];
    logic [30:0]    r_dq [h2p_pkg::DIV_STAGES+1][3];
    logic [31:0]    r_dden [h2p_pkg::DIV_STAGES+1];
    logic           r_dsat [h2p_pkg::DIV_STAGES+1][3];
    logic           r_dneg [h2p_pkg::DIV_STAGES+1][3];
    logic           r_dzero [h2p_pkg::DIV_STAGES+1][3];
    logic [32:0]    n_drem [h2p_pkg::DIV_STAGES][3];
    logic [30:0]    n_dq [h2p_pkg::DIV_STAGES][3];
    h2p_pkg::t_rot3 r_rot;
    h2p_pkg::t_rot3 n_rot;

    // magnitudes of the incoming components
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_neg[k] = 33'd0 - i_num[k];
            w_mag[k] = i_num[k][32] ? w_neg[k][31:0] : i_num[k][31:0];
        end
    end

    // square root, one result bit per stage
    always_comb begin
        logic [65:0] t;
        for (int j = 0; j < 32; j++) begin
            t = ({34'd0, r_root[j]} << (32 - j)) | (66'd1 << (2 * (31 - j)));
            if ({2'b00, r_rem[j]} >= t) begin
                n_rem[j]  = 64'({2'b00, r_rem[j]} - t);
                n_root[j] = r_root[j] | (32'd1 << (31 - j));
            end else begin
                n_rem[j]  = r_rem[j];
                n_root[j] = r_root[j];
            end
        end
    end

    // magnitudes of the delayed numerators
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pneg[k] = 33'd0 - r_nd[h2p_pkg::NORM_LAT-1][k];
            w_pm[k]   = r_nd[h2p_pkg::NORM_LAT-1][k][32] ? w_pneg[k][31:0]
                                                         : r_nd[h2p_pkg::NORM_LAT-1][k][31:0];
        end
    end

    // restoring divide, one quotient bit per stage
    always_comb begin
        logic [32:0] x;
        for (int j = 0; j < h2p_pkg::DIV_STAGES; j++) begin
            for (int k = 0; k < 3; k++) begin
                x = (j == 0) ? r_drem[j][k] : {r_drem[j][k][31:0], 1'b0};
                if (x >= {1'b0, r_dden[j]}) begin
                    n_drem[j][k] = x - {1'b0, r_dden[j]};
                    n_dq[j][k]   = {r_dq[j][k][29:0], 1'b1};
                end else begin
                    n_drem[j][k] = x;
                    n_dq[j][k]   = {r_dq[j][k][29:0], 1'b0};
                end
            end
        end
    end

    // clamp and sign of each quotient
    always_comb begin
        logic [30:0] q;
        for (int k = 0; k < 3; k++) begin
            q = r_dq[h2p_pkg::DIV_STAGES][k];
            if (r_dsat[h2p_pkg::DIV_STAGES][k] || q > h2p_pkg::ROT_ONE) begin
                q = h2p_pkg::ROT_ONE;
            end
            if (r_dzero[h2p_pkg::DIV_STAGES][k]) begin
                n_rot[k] = '0;
            end else if (r_dneg[h2p_pkg::DIV_STAGES][k]) begin
                n_rot[k] = 32'd0 - {1'b0, q};
            end else begin
                n_rot[k] = {1'b0, q};
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= {32'd0, w_mag[k]} * {32'd0, w_mag[k]};
            end
            r_rem[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_root[0] <= '0;
            for (int j = 0; j < 32; j++) begin
                r_rem[j+1]  <= n_rem[j];
                r_root[j+1] <= n_root[j];
            end

            r_nd[0] <= i_num;
            for (int j = 1; j < h2p_pkg::NORM_LAT; j++) begin
                r_nd[j] <= r_nd[j-1];
            end

            r_dden[0] <= r_root[32];
            for (int k = 0; k < 3; k++) begin
                r_drem[0][k]  <= {1'b0, w_pm[k]};
                r_dq[0][k]    <= '0;
                r_dzero[0][k] <= (w_pm[k] == 32'd0);
                r_dsat[0][k]  <= (w_pm[k] != 32'd0) && ({1'b0, w_pm[k]} >= {r_root[32], 1'b0});
                r_dneg[0][k]  <= r_nd[h2p_pkg::NORM_LAT-1][k][32];
            end
            for (int j = 0; j < h2p_pkg::DIV_STAGES; j++) begin
                r_dden[j+1] <= r_dden[j];
                for (int k = 0; k < 3; k++) begin
                    r_drem[j+1][k]  <= n_drem[j][k];
                    r_dq[j+1][k]    <= n_dq[j][k];
                    r_dzero[j+1][k] <= r_dzero[j][k];
                    r_dsat[j+1][k]  <= r_dsat[j][k];
                    r_dneg[j+1][k]  <= r_dneg[j][k];
                end
            end

            r_rot <= n_rot;
        end
    end

    assign o_norm = r_root[32];
    assign o_rot  = r_rot;

endmodule

/* src/homography_to_pose_unit.sv */
// homography to camera pose
//
// input channel: i_valid with the eight homography entries i_h_0..i_h_7
// (signed Q16.16, ninth entry taken as one); a word is taken at a clock edge
// with i_valid high and o_stall low.
// output channel: o_valid with the translation o_pos_* (signed Q16.16) and
// the rotation o_rot_* (signed Q2.30); a word is taken with o_valid high and
// i_stall low.
//
// a new word can enter in every cycle unless o_stall is raised. the depth
// comes from two chained column units, each a 32-stage square root followed
// by 31-stage dividers, plus the multiply stages for the Gram-Schmidt step
// and the cross product.
//
// reset clears every valid bit in the pipeline; the datapath is not cleared.
// while the output word waits under i_stall the whole pipeline holds and
// o_stall is raised; when the output register is empty the pipeline keeps
// moving, so empty slots at the front drain even under i_stall.
module homography_to_pose_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_h_0,
    input  logic [31:0] i_h_1,
    input  logic [31:0] i_h_2,
    input  logic [31:0] i_h_3,
    input  logic [31:0] i_h_4,
    input  logic [31:0] i_h_5,
    input  logic [31:0] i_h_6,
    input  logic [31:0] i_h_7,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic [31:0] o_pos_z,
    output logic [31:0] o_rot_00,
    output logic [31:0] o_rot_10,
    output logic [31:0] o_rot_20,
    output logic [31:0] o_rot_01,
    output logic [31:0] o_rot_11,
    output logic [31:0] o_rot_21,
    output logic [31:0] o_rot_02,
    output logic [31:0] o_rot_12,
    output logic [31:0] o_rot_22
);

    localparam int L = h2p_pkg::COL_LAT;
    localparam int T = h2p_pkg::PIPE_LAT;
    localparam int S = h2p_pkg::DIV_STAGES;

    logic                  w_en;
    logic                  r_vld [T];
    h2p_pkg::t_vec3        w_c;
    h2p_pkg::t_vec3        w_col0;
    logic [31:0]           w_n1;
    logic [31:0]           w_n2;
    h2p_pkg::t_rot3        w_r0;
    h2p_pkg::t_rot3        w_r1;
    h2p_pkg::t_rot3        w_r2_unused;

    h2p_pkg::t_vec3        r_cd [L+3];
    logic [1:0][31:0]      r_hd [L];
    h2p_pkg::t_rot3        r_r0d [L+4];

    logic [33:0]           r_srem [S+1];
    logic [30:0]           r_sq [S+1];
    logic [32:0]           r_sdd [S+1];
    logic                  r_ssat [S+1];
    logic [33:0]           n_srem [S];
    logic [30:0]           n_sq [S];
    logic [31:0]           r_s;

    logic signed [64:0]    r_pp [2];
    logic [31:0]           r_pz;
    logic [2:0][31:0]      r_pos;
    logic [2:0][31:0]      r_posd [L+4];

    logic signed [64:0]    r_dp [3];
    logic signed [36:0]    r_dot;
    logic signed [66:0]    w_dsum;
    logic signed [68:0]    r_qp [3];
    h2p_pkg::t_vec3        r_u;
    h2p_pkg::t_vec3        n_u;

    h2p_pkg::t_rot3        r_r0x;
    h2p_pkg::t_rot3        r_r1x;
    logic signed [63:0]    r_xp [6];
    h2p_pkg::t_rot3        r_o0;
    h2p_pkg::t_rot3        r_o1;
    h2p_pkg::t_rot3        r_o2;
    h2p_pkg::t_rot3        n_o2;

    // whole pipeline advances unless the output word is held
    assign w_en    = !(r_vld[T-1] && i_stall);
    assign o_stall = !w_en;

    // column vectors with the third row negated
    assign w_c[0]    = {i_h_1[31], i_h_1};
    assign w_c[1]    = {i_h_4[31], i_h_4};
    assign w_c[2]    = 33'd0 - {i_h_7[31], i_h_7};
    assign w_col0[0] = {i_h_0[31], i_h_0};
    assign w_col0[1] = {i_h_3[31], i_h_3};
    assign w_col0[2] = 33'd0 - {i_h_6[31], i_h_6};

    // first rotation column and its norm
    h2p_column u_col0 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_col0),
        .o_norm (w_n1),
        .o_rot  (w_r0)
    );

    // norm of the second homography column
    h2p_column u_coln (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_c),
        .o_norm (w_n2),
        .o_rot  (w_r2_unused)
    );

    // second rotation column from the orthogonalized vector
    h2p_column u_col1 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_u),
        .o_norm (),
        .o_rot  (w_r1)
    );

    // scale divider, two in Q16.16 over the norm sum
    always_comb begin
        logic [33:0] x;
        for (int j = 0; j < S; j++) begin
            x = (j == 0) ? r_srem[j] : {r_srem[j][32:0], 1'b0};
            if (x >= {1'b0, r_sdd[j]}) begin
                n_srem[j] = x - {1'b0, r_sdd[j]};
                n_sq[j]   = {r_sq[j][29:0], 1'b1};
            end else begin
                n_srem[j] = x;
                n_sq[j]   = {r_sq[j][29:0], 1'b0};
            end
        end
    end

    // Gram-Schmidt: subtract the projection on the first column
    always_comb begin
        logic [31:0] us;
        for (int k = 0; k < 3; k++) begin
            us = h2p_pkg::sat_data(72'($signed(r_cd[L+2][k])) - (72'(r_qp[k]) >>> 30));
            n_u[k] = {us[31], us};
        end
    end

    assign w_dsum = 67'(r_dp[0]) + 67'(r_dp[1]) + 67'(r_dp[2]);

    // cross product column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_o2[k] = h2p_pkg::sat_rot(72'(65'(r_xp[2*k]) - 65'(r_xp[2*k+1])) >>> 30);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < T; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < T; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // delay lines
            r_cd[0] <= w_c;
            for (int j = 1; j < L + 3; j++) begin
                r_cd[j] <= r_cd[j-1];
            end
            r_hd[0] <= {i_h_5, i_h_2};
            for (int j = 1; j < L; j++) begin
                r_hd[j] <= r_hd[j-1];
            end
            r_r0d[0] <= w_r0;
            for (int j = 1; j < L + 4; j++) begin
                r_r0d[j] <= r_r0d[j-1];
            end

            // scale
            r_srem[0] <= 34'd8;
            r_sq[0]   <= '0;
            r_sdd[0]  <= {1'b0, w_n1} + {1'b0, w_n2};
            r_ssat[0] <= ({1'b0, w_n1} + {1'b0, w_n2}) <= 33'd4;
            for (int j = 0; j < S; j++) begin
                r_srem[j+1] <= n_srem[j];
                r_sq[j+1]   <= n_sq[j];
                r_sdd[j+1]  <= r_sdd[j];
                r_ssat[j+1] <= r_ssat[j];
            end
            r_s <= r_ssat[S] ? h2p_pkg::DATA_MAX : {1'b0, r_sq[S]};

            // translation
            r_pp[0] <= $signed({1'b0, r_s}) * $signed(r_hd[L-1][0]);
            r_pp[1] <= $signed({1'b0, r_s}) * $signed(r_hd[L-1][1]);
            r_pz    <= 32'd0 - r_s;
            r_pos[0] <= h2p_pkg::sat_data(72'(r_pp[0]) >>> h2p_pkg::FRAC_BITS);
            r_pos[1] <= h2p_pkg::sat_data(72'(r_pp[1]) >>> h2p_pkg::FRAC_BITS);
            r_pos[2] <= r_pz;
            r_posd[0] <= r_pos;
            for (int j = 1; j < L + 4; j++) begin
                r_posd[j] <= r_posd[j-1];
            end

            // projection of the second column on the first
            for (int k = 0; k < 3; k++) begin
                r_dp[k] <= $signed(w_r0[k]) * $signed(r_cd[L-1][k]);
                r_qp[k] <= $signed(r_r0d[1][k]) * r_dot;
            end
            r_dot <= w_dsum[66:30];
            r_u   <= n_u;

            // cross product terms
            r_r0x <= r_r0d[L+3];
            r_r1x <= w_r1;
            r_xp[0] <= $signed(r_r0d[L+3][1]) * $signed(w_r1[2]);
            r_xp[1] <= $signed(r_r0d[L+3][2]) * $signed(w_r1[1]);
            r_xp[2] <= $signed(r_r0d[L+3][2]) * $signed(w_r1[0]);
            r_xp[3] <= $signed(r_r0d[L+3][0]) * $signed(w_r1[2]);
            r_xp[4] <= $signed(r_r0d[L+3][0]) * $signed(w_r1[1]);
            r_xp[5] <= $signed(r_r0d[L+3][1]) * $signed(w_r1[0]);

            // output word
            r_o0 <= r_r0x;
            r_o1 <= r_r1x;
            r_o2 <= n_o2;
        end
    end

    assign o_valid  = r_vld[T-1];
    assign o_pos_x  = r_posd[L+3][0];
    assign o_pos_y  = r_posd[L+3][1];
    assign o_pos_z  = r_posd[L+3][2];
    assign o_rot_00 = r_o0[0];
    assign o_rot_10 = r_o0[1];
    assign o_rot_20 = r_o0[2];
    assign o_rot_01 = r_o1[0];
    assign o_rot_11 = r_o1[1];
    assign o_rot_21 = r_o1[2];
    assign o_rot_02 = r_o2[0];
    assign o_rot_12 = r_o2[1];
    assign o_rot_22 = r_o2[2];

endmodule

/* src/h2p_checker.sv */
module h2p_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_pos_x,
    input logic [31:0] o_pos_z,
    input logic [31:0] o_rot_00,
    input logic [31:0] o_rot_22
);

    // a held output word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_rot_22))
        else $error("held output word changed");

    // input side stalls only behind a held output word
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output");

    // depth is always in front of the camera
    a_posz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pos_z[31])
        else $error("translation z not negative");

    // rotation entries stay within plus or minus one
    a_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_rot_00) <= 32'sd1073741824)
                 && ($signed(o_rot_00) >= -32'sd1073741824)
                 && ($signed(o_rot_22) <= 32'sd1073741824)
                 && ($signed(o_rot_22) >= -32'sd1073741824))
        else $error("rotation entry out of range");

endmodule

bind homography_to_pose_unit h2p_checker u_h2p_checker (.*);

/* bench/homography_to_pose_unit_tb.sv */
`timescale 1ns / 100ps

module homography_to_pose_unit_tb;

    localparam int    N_RANDOM    = 1030;
    localparam int    PAUSE_AT    = 600;
    localparam int    CYCLE_LIMIT = 400000;
    localparam longint DMAX_L     = 64'sd2147483647;
    localparam longint DMIN_L     = -64'sd2147483648;
    localparam longint RONE_L     = 64'sd1073741824;

    typedef logic [7:0][31:0]  t_homog;
    typedef logic [11:0][31:0] t_pose;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    t_homog      h_drv = '0;
    t_pose       pose_act;

    t_homog      homog_q[$];
    t_pose       pose_q[$];
    int          n_sent = 0;
    int          n_recv = 0;
    int          n_err = 0;
    int          cyc = 0;
    bit          paused_once = 1'b0;
    string       field_name[12] = '{"pos_x", "pos_y", "pos_z", "rot_00", "rot_10", "rot_20",
                                    "rot_01", "rot_11", "rot_21", "rot_02", "rot_12", "rot_22"};

    homography_to_pose_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_h_0(h_drv[0]), .i_h_1(h_drv[1]), .i_h_2(h_drv[2]), .i_h_3(h_drv[3]),
        .i_h_4(h_drv[4]), .i_h_5(h_drv[5]), .i_h_6(h_drv[6]), .i_h_7(h_drv[7]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pos_x(pose_act[0]), .o_pos_y(pose_act[1]), .o_pos_z(pose_act[2]),
        .o_rot_00(pose_act[3]), .o_rot_10(pose_act[4]), .o_rot_20(pose_act[5]),
        .o_rot_01(pose_act[6]), .o_rot_11(pose_act[7]), .o_rot_21(pose_act[8]),
        .o_rot_02(pose_act[9]), .o_rot_12(pose_act[10]), .o_rot_22(pose_act[11])
    );

    always #5 i_clk = ~i_clk;

    // integer square root, floor
    function automatic longint unsigned isqrt64(input longint unsigned x);
        longint unsigned acc;
        longint unsigned b;
        acc = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= acc + b) begin
                x = x - (acc + b);
                acc = (acc >> 1) + b;
            end else begin
                acc = acc >> 1;
            end
            b = b >> 2;
        end
        return acc;
    endfunction

    function automatic longint unsigned vec_len(input longint a, input longint b,
                                                input longint c);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mc;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        return isqrt64(ma * ma + mb * mb + mc * mc);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // num / den in Q2.30, toward zero, limited to one
    function automatic longint unit_quot(input longint num, input longint unsigned den);
        longint unsigned m;
        longint unsigned q;
        m = (num < 0) ? -num : num;
        if (m == 0) return 0;
        if (den == 0) q = RONE_L;
        else q = (m << h2p_pkg::ROT_FRAC) / den;
        if (q > RONE_L) q = RONE_L;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint cross_term(input longint a, input longint b,
                                          input longint c, input longint d);
        return clamp((a * b - c * d) >>> h2p_pkg::ROT_FRAC, -RONE_L, RONE_L);
    endfunction

    // pose from one homography
    function automatic t_pose pose_of(input t_homog w);
        longint h[8];
        longint r[3][3];
        longint c[3];
        longint u[3];
        longint unsigned n1, n2, den, s, n3;
        longint dot;
        t_pose p;
        for (int i = 0; i < 8; i++) h[i] = longint'($signed(w[i]));
        n1 = vec_len(h[0], h[3], h[6]);
        n2 = vec_len(h[1], h[4], h[7]);
        den = n1 + n2;
        if (den == 0) s = DMAX_L;
        else begin
            s = (64'd2 << (2 * h2p_pkg::FRAC_BITS)) / den;
            if (s > DMAX_L) s = DMAX_L;
        end
        p[0] = 32'(clamp((longint'(s) * h[2]) >>> h2p_pkg::FRAC_BITS, DMIN_L, DMAX_L));
        p[1] = 32'(clamp((longint'(s) * h[5]) >>> h2p_pkg::FRAC_BITS, DMIN_L, DMAX_L));
        p[2] = 32'(-longint'(s));
        r[0][0] = unit_quot(h[0], n1);
        r[1][0] = unit_quot(h[3], n1);
        r[2][0] = unit_quot(-h[6], n1);
        c[0] = h[1];
        c[1] = h[4];
        c[2] = -h[7];
        // gram-schmidt against the first column
        dot = (r[0][0] * c[0] + r[1][0] * c[1] + r[2][0] * c[2]) >>> h2p_pkg::ROT_FRAC;
        for (int i = 0; i < 3; i++)
            u[i] = clamp(c[i] - ((r[i][0] * dot) >>> h2p_pkg::ROT_FRAC), DMIN_L, DMAX_L);
        n3 = vec_len(u[0], u[1], u[2]);
        for (int i = 0; i < 3; i++) r[i][1] = unit_quot(u[i], n3);
        r[0][2] = cross_term(r[1][0], r[2][1], r[2][0], r[1][1]);
        r[1][2] = cross_term(r[2][0], r[0][1], r[0][0], r[2][1]);
        r[2][2] = cross_term(r[0][0], r[1][1], r[1][0], r[0][1]);
        for (int i = 0; i < 9; i++) p[3 + i] = 32'(r[i % 3][i / 3]);
        return p;
    endfunction

    function automatic logic [31:0] rand_entry(input int kind);
        unique case (kind)
            0: return $urandom;
            1: return $urandom_range(2 * 65536 * 4) - 65536 * 4;
            2: return $urandom_range(2 * 65536 * 64) - 65536 * 64;
            default: return 32'h0;
        endcase
    endfunction

    // stimulus: directed corners, then random homographies
    initial begin
        t_homog w;
        int k;
        homog_q.push_back('0);
        homog_q.push_back({8{32'h7fff_ffff}});
        homog_q.push_back({8{32'h8000_0000}});
        homog_q.push_back({8{32'hffff_ffff}});
        homog_q.push_back({8{32'h0000_0001}});
        w = '0; w[0] = 32'h1_0000; w[4] = 32'h1_0000;
        homog_q.push_back(w);
        w[2] = 32'h3_0000; w[5] = 32'hfffe_0000; w[6] = 32'h100; w[7] = 32'hffff_ff00;
        homog_q.push_back(w);
        // parallel columns
        w = '0; w[0] = 32'h2_0000; w[1] = 32'h4_0000; w[3] = 32'h1_0000; w[4] = 32'h2_0000;
        homog_q.push_back(w);
        // first column zero, second column zero
        w = '0; w[1] = 32'h1_0000; w[2] = 32'h7fff_ffff; w[5] = 32'h8000_0000;
        homog_q.push_back(w);
        w = '0; w[0] = 32'hffff_0000; w[2] = 32'h1234; w[5] = 32'hffff_1234;
        homog_q.push_back(w);
        // zero norms with extreme translation
        w = '0; w[2] = 32'h8000_0000; w[5] = 32'h7fff_ffff;
        homog_q.push_back(w);
        w = '0; w[2] = 32'h1; w[5] = 32'hffff_ffff;
        homog_q.push_back(w);
        w = {8{32'h8000_0000}}; w[1] = 32'h7fff_ffff; w[4] = 32'h7fff_ffff;
        homog_q.push_back(w);
        w = '0; w[6] = 32'h8000_0000; w[7] = 32'h8000_0000;
        homog_q.push_back(w);
        for (int i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(99);
            for (int j = 0; j < 8; j++) begin
                if (k < 20) w[j] = rand_entry(0);
                else if (k < 55) w[j] = rand_entry(1);
                else if (k < 90) w[j] = rand_entry(2);
                else w[j] = ($urandom_range(2) == 0) ? rand_entry(3) : rand_entry(1);
            end
            homog_q.push_back(w);
        end
    end

    // reset and end of run
    initial begin
        int total;
        total = 0;
        repeat (11) @(posedge i_clk);
        total = homog_q.size() + n_sent;
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (n_sent == total && !i_valid && pose_q.size() == 0);
        repeat (h2p_pkg::PIPE_LAT + 20) @(posedge i_clk);
        $display("covered %0d homographies, %0d poses checked, %0d mismatches",
                 n_sent, n_recv, n_err);
        $display("corners, zero columns, parallel columns and random stalls on both sides");
        if (n_err == 0 && pose_q.size() == 0) begin
            $display("homography_to_pose_unit_tb: done, clean");
        end else begin
            $display("homography_to_pose_unit_tb: done, errors");
        end
        $finish;
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("homography_to_pose_unit_tb: done, errors");
            $finish;
        end
    end

    // driver for the input word
    always @(posedge i_clk) begin
        bit quiet;
        bit take;
        quiet = (cyc > 2000 && cyc < 3500);
        take = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || take) begin
            if (take) begin
                pose_q.push_back(pose_of(h_drv));
                n_sent++;
            end
            if (n_sent == PAUSE_AT && !paused_once) begin
                i_valid <= 1'b0;
                if (pose_q.size() == 0) paused_once = 1'b1;
            end else if (homog_q.size() == 0 || (!quiet && $urandom_range(99) < 23)) begin
                i_valid <= 1'b0;
            end else begin
                h_drv <= homog_q.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // monitor for the output word
    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_recv++;
                if (pose_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected pose word at cycle %0d", cyc);
                end else begin
                    want = pose_q.pop_front();
                    for (int i = 0; i < 12; i++) begin
                        if (want[i] !== pose_act[i]) begin
                            n_err++;
                            if (n_err <= 10)
                                $display("pose %0d %s: expected %h, got %h",
                                         n_recv, field_name[i], want[i], pose_act[i]);
                        end
                    end
                end
            end
            i_stall <= (cyc > 2000 && cyc < 3500) ? 1'b0 : ($urandom_range(99) < 23);
        end
    end

endmodule
